@@ hw/rtl/qbp_pkg.sv @@
`default_nettype none
package qbp_pkg;

    localparam int PROB_FRAC_BITS = 16;
    localparam int POS_W          = 32;
    localparam int GRID_W         = 31;
    localparam int PARAM_W        = 16;
    localparam int PROB_W         = 20;
    localparam int Q_W            = 17;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 32;
    localparam int OUT_TDATA_W    = 232;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_STEP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_DRIFT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BRANCH_PARAM = 2'd2;

    localparam logic [GRID_W-1:0]  GRID_RST  = 31'd16777216;
    localparam logic [POS_W-1:0]   DRIFT_RST = 32'd0;
    localparam logic [PARAM_W-1:0] PARAM_RST = 16'd5461;

    typedef logic [3:0][POS_W-1:0] t_pos;

    // classified node handed from front to back
    typedef struct packed {
        t_pos              pos;
        logic [GRID_W-1:0] mag;
        logic              neg;
        logic              case_two;
    } t_mid;

endpackage
`default_nettype wire

@@ hw/rtl/qbp_front.sv @@
`default_nettype none
module qbp_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [qbp_pkg::POS_W-1:0]     i_log_price,
    input  logic [qbp_pkg::GRID_W-1:0]    i_grid,
    input  logic [qbp_pkg::POS_W-1:0]     i_drift,
    input  logic                          i_room,
    output logic                          o_valid,
    output qbp_pkg::t_mid                 o_mid
);
    import qbp_pkg::*;

    localparam int NB = POS_W;
    localparam int SW = POS_W + 3;

    logic                    r_v   [0:NB];
    logic [GRID_W-1:0]       r_rem [0:NB];
    logic [POS_W-1:0]        r_a   [0:NB];
    logic [POS_W-1:0]        r_x   [0:NB];

    logic                    ce;
    logic [POS_W-1:0]        w_abs;

    assign ce      = i_room;
    assign o_ready = ce;
    assign w_abs   = i_log_price[POS_W-1] ? (~i_log_price + 1'b1) : i_log_price;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (ce) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_rem[0] <= '0;
            r_a[0]   <= w_abs;
            r_x[0]   <= i_log_price;
        end
    end

    // restoring division |x| / grid, one quotient bit per stage
    for (genvar k = 0; k < NB; k++) begin : g_div
        logic [GRID_W:0] t;
        logic [GRID_W:0] diff;
        logic            ge;
        assign t    = {r_rem[k], r_a[k][POS_W-1]};
        assign ge   = (t >= {1'b0, i_grid});
        assign diff = t - {1'b0, i_grid};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (ce) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (ce) begin
                r_rem[k+1] <= ge ? diff[GRID_W-1:0] : t[GRID_W-1:0];
                r_a[k+1]   <= {r_a[k][POS_W-2:0], 1'b0};
                r_x[k+1]   <= r_x[k];
            end
        end
    end

    // n = x - (j-1)*grid, in (0, grid]
    logic [GRID_W-1:0]   w_ra;
    logic [GRID_W-1:0]   w_n;
    logic signed [SW-1:0] w_base;
    logic                w_case_one;
    logic                w_half;
    logic [GRID_W-1:0]   w_mag;

    assign w_ra = r_rem[NB];
    assign w_n  = (w_ra == '0) ? i_grid
                : (r_x[NB][POS_W-1] ? (i_grid - w_ra) : w_ra);
    assign w_base = SW'(signed'(r_x[NB])) - SW'(w_n) + SW'(signed'(i_drift));
    assign w_case_one = ({w_n, 1'b0} > {1'b0, i_grid});
    assign w_half     = ({w_n, 1'b0} == {1'b0, i_grid});
    assign w_mag = w_case_one ? (i_grid - w_n) : (w_half ? '0 : w_n);

    logic                 r_c1_v;
    logic signed [SW-1:0] r_c1_base;
    logic [GRID_W-1:0]    r_c1_mag;
    logic                 r_c1_one;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_v <= 1'b0;
        end else if (ce) begin
            r_c1_v <= r_v[NB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_c1_base <= w_base;
            r_c1_mag  <= w_mag;
            r_c1_one  <= w_case_one;
        end
    end

    function automatic logic [POS_W-1:0] sat_pos(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        hi = SW'({1'b0, {(POS_W-1){1'b1}}});
        lo = -hi - 1;
        if (v > hi)      sat_pos = hi[POS_W-1:0];
        else if (v < lo) sat_pos = lo[POS_W-1:0];
        else             sat_pos = v[POS_W-1:0];
    endfunction

    logic signed [SW-1:0] w_g;
    t_pos                 w_pos;
    assign w_g = SW'(i_grid);
    assign w_pos[0] = sat_pos(r_c1_base + (w_g <<< 1));
    assign w_pos[1] = sat_pos(r_c1_base + w_g);
    assign w_pos[2] = sat_pos(r_c1_base);
    assign w_pos[3] = sat_pos(r_c1_base - w_g);

    logic r_c2_v;
    t_mid r_c2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c2_v <= 1'b0;
        end else if (ce) begin
            r_c2_v <= r_c1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_c2.pos      <= w_pos;
            r_c2.mag      <= r_c1_mag;
            r_c2.neg      <= r_c1_one;
            r_c2.case_two <= ~r_c1_one;
        end
    end

    assign o_valid = r_c2_v;
    assign o_mid   = r_c2;

endmodule
`default_nettype wire

@@ hw/rtl/qbp_queue.sv @@
`default_nettype none
module qbp_queue #(
    parameter int DEPTH = qbp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  qbp_pkg::t_mid i_data,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_nempty,
    output qbp_pkg::t_mid o_data
);
    import qbp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_mid            r_mem [0:DEPTH-1];
    logic [AW-1:0]   r_wp;
    logic [AW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;
    logic [AW-1:0]   n_wp;
    logic [AW-1:0]   n_rp;

    assign n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= n_wp;
            if (i_pop)  r_rp <= n_rp;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_full   = (r_cnt == CW'(DEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_data   = r_mem[r_rp];

endmodule
`default_nettype wire

@@ hw/rtl/qbp_back.sv @@
`default_nettype none
module qbp_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  qbp_pkg::t_mid                       i_mid,
    output logic                                o_pop,
    input  logic [qbp_pkg::GRID_W-1:0]          i_grid,
    input  logic [qbp_pkg::PARAM_W-1:0]         i_param,
    output logic                                o_valid,
    input  logic                                i_ready,
    output qbp_pkg::t_pos                       o_pos,
    output logic [3:0][qbp_pkg::PROB_W-1:0]     o_prob,
    output logic [qbp_pkg::Q_W-1:0]             o_q,
    output logic                                o_case
);
    import qbp_pkg::*;

    localparam int PB = PROB_FRAC_BITS;
    localparam int RW = GRID_W + 1;
    localparam int QW = PB + 1;
    localparam int MW = 2 * QW;
    localparam int W  = 2 * PB + 4;

    logic ce;
    assign ce    = !o_valid || i_ready;
    assign o_pop = ce && i_valid;

    logic            r_v   [0:PB];
    logic [RW-1:0]   r_rem [0:PB];
    logic [PB-1:0]   r_nb  [0:PB];
    logic [PB-1:0]   r_quo [0:PB];
    t_pos            r_pos [0:PB];
    logic            r_neg [0:PB];
    logic            r_c2  [0:PB];

    logic [RW-1:0]   w_rem0;
    logic [RW-1:0]   w_gs;
    assign w_gs   = {1'b0, i_grid} >> PB;
    assign w_rem0 = {i_mid.mag, 1'b0} + w_gs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (ce) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_rem[0] <= w_rem0;
            r_nb[0]  <= i_grid[PB-1:0];
            r_quo[0] <= '0;
            r_pos[0] <= i_mid.pos;
            r_neg[0] <= i_mid.neg;
            r_c2[0]  <= i_mid.case_two;
        end
    end

    // restoring division (|d| * 2^(PB+1) + grid) / (2 * grid)
    for (genvar k = 0; k < PB; k++) begin : g_div
        logic [RW:0] t;
        logic [RW:0] diff;
        logic        ge;
        assign t    = {r_rem[k], r_nb[k][PB-1]};
        assign ge   = (t >= {1'b0, i_grid, 1'b0});
        assign diff = t - {1'b0, i_grid, 1'b0};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (ce) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (ce) begin
                r_rem[k+1] <= ge ? diff[RW-1:0] : t[RW-1:0];
                r_nb[k+1]  <= {r_nb[k][PB-2:0], 1'b0};
                r_quo[k+1] <= {r_quo[k][PB-2:0], ge};
                r_pos[k+1] <= r_pos[k];
                r_neg[k+1] <= r_neg[k];
                r_c2[k+1]  <= r_c2[k];
            end
        end
    end

    logic signed [QW-1:0] w_q;
    assign w_q = r_neg[PB] ? -signed'({1'b0, r_quo[PB]}) : signed'({1'b0, r_quo[PB]});

    logic                 r_sq_v;
    logic signed [QW-1:0] r_sq_q;
    logic signed [MW-1:0] r_sq_qq;
    t_pos                 r_sq_pos;
    logic                 r_sq_c2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v <= 1'b0;
        end else if (ce) begin
            r_sq_v <= r_v[PB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_sq_q   <= w_q;
            r_sq_qq  <= w_q * w_q;
            r_sq_pos <= r_pos[PB];
            r_sq_c2  <= r_c2[PB];
        end
    end

    localparam logic signed [W-1:0] ONE2  = W'(1) << (2 * PB);
    localparam logic signed [W-1:0] ONE   = W'(1) << PB;
    localparam logic signed [W-1:0] HALF  = W'(1) << (PB - 1);

    function automatic logic [PROB_W-1:0] sat_prob(input logic signed [W-1:0] v);
        logic signed [W-1:0] hi;
        logic signed [W-1:0] lo;
        hi = W'({1'b0, {(PROB_W-1){1'b1}}});
        lo = -hi - 1;
        if (v > hi)      sat_prob = hi[PROB_W-1:0];
        else if (v < lo) sat_prob = lo[PROB_W-1:0];
        else             sat_prob = v[PROB_W-1:0];
    endfunction

    function automatic logic [Q_W-1:0] sat_q(input logic signed [W-1:0] v);
        logic signed [W-1:0] hi;
        logic signed [W-1:0] lo;
        hi = W'({1'b0, {(Q_W-1){1'b1}}});
        lo = -hi - 1;
        if (v > hi)      sat_q = hi[Q_W-1:0];
        else if (v < lo) sat_q = lo[Q_W-1:0];
        else             sat_q = v[Q_W-1:0];
    endfunction

    logic signed [W-1:0] w_qx;
    logic signed [W-1:0] w_qqx;
    logic signed [W-1:0] w_p;
    logic signed [W-1:0] w_p3;
    logic signed [W-1:0] w_s;
    logic signed [W-1:0] w_hp;
    logic signed [W-1:0] w_hm;
    logic signed [W-1:0] w_pr [0:3];

    assign w_qx  = W'(r_sq_q);
    assign w_qqx = W'(r_sq_qq);
    assign w_p   = W'({1'b0, i_param});
    assign w_p3  = w_p + (w_p <<< 1);
    assign w_s   = (w_qqx + HALF) >>> PB;
    assign w_hp  = (ONE2 + (w_qx <<< PB) + w_qqx + ONE) >>> (PB + 1);
    assign w_hm  = (ONE2 - (w_qx <<< PB) + w_qqx + ONE) >>> (PB + 1);

    always_comb begin
        if (r_sq_c2) begin
            w_pr[0] = w_p;
            w_pr[1] = w_hp - w_p3;
            w_pr[2] = w_p3 - w_s;
            w_pr[3] = w_hm - w_p;
        end else begin
            w_pr[0] = w_hp - w_p;
            w_pr[1] = w_p3 - w_s;
            w_pr[2] = w_hm - w_p3;
            w_pr[3] = w_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (ce) begin
            o_valid <= r_sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            o_pos     <= r_sq_pos;
            o_prob[0] <= sat_prob(w_pr[0]);
            o_prob[1] <= sat_prob(w_pr[1]);
            o_prob[2] <= sat_prob(w_pr[2]);
            o_prob[3] <= sat_prob(w_pr[3]);
            o_q       <= sat_q(w_qx);
            o_case    <= r_sq_c2;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/quadrinomial_branch_probabilities.sv @@
// Throughput: one node per cycle while the output is not stalled; a 32-stage restoring
// divider for the cell index and a 16-stage divider for q, both one bit per stage, form
// the bulk of the pipeline.
// Reset (i_rst_n low, synchronous) empties the pipelines and queue and loads
// grid_step = 16777216, level_drift = 0, branch_param = 5461.
`default_nettype none
module quadrinomial_branch_probabilities #(
    parameter int QUEUE_DEPTH = qbp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [qbp_pkg::POS_W-1:0]             s_axis_tdata,  // log_price
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // child_top, child_upper, child_lower, child_bottom, prob_top, prob_upper,
    // prob_lower, prob_bottom, offset_q, zero pad
    output logic [qbp_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    output logic [0:0]                            m_axis_tuser,  // branch_case
    input  logic                                  i_cfg_we,
    input  logic [qbp_pkg::CFG_IDX_W-1:0]         i_cfg_addr,
    input  logic [qbp_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import qbp_pkg::*;

    logic [GRID_W-1:0]  r_grid;
    logic [POS_W-1:0]   r_drift;
    logic [PARAM_W-1:0] r_param;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid  <= GRID_RST;
            r_drift <= DRIFT_RST;
            r_param <= PARAM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_GRID_STEP:    r_grid  <= i_cfg_data[GRID_W-1:0];
                CFG_LEVEL_DRIFT:  r_drift <= i_cfg_data[POS_W-1:0];
                CFG_BRANCH_PARAM: r_param <= i_cfg_data[PARAM_W-1:0];
                default: ;
            endcase
        end
    end

    logic [GRID_W-1:0] w_grid;
    assign w_grid = (r_grid == '0) ? GRID_W'(1) : r_grid;

    logic q_full;
    logic q_nempty;
    logic f_valid;
    logic b_pop;
    t_mid f_mid;
    t_mid q_mid;

    qbp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_log_price (s_axis_tdata),
        .i_grid      (w_grid),
        .i_drift     (r_drift),
        .i_room      (!q_full),
        .o_valid     (f_valid),
        .o_mid       (f_mid)
    );

    qbp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (f_valid && !q_full),
        .i_data   (f_mid),
        .i_pop    (b_pop),
        .o_full   (q_full),
        .o_nempty (q_nempty),
        .o_data   (q_mid)
    );

    t_pos                    b_pos;
    logic [3:0][PROB_W-1:0]  b_prob;
    logic [Q_W-1:0]          b_q;
    logic                    b_case;

    qbp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_nempty),
        .i_mid   (q_mid),
        .o_pop   (b_pop),
        .i_grid  (w_grid),
        .i_param (r_param),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_pos   (b_pos),
        .o_prob  (b_prob),
        .o_q     (b_q),
        .o_case  (b_case)
    );

    assign m_axis_tdata = {7'd0, b_q, b_prob[3], b_prob[2], b_prob[1], b_prob[0],
                           b_pos[3], b_pos[2], b_pos[1], b_pos[0]};
    assign m_axis_tuser = b_case;

endmodule
`default_nettype wire
